FILE: design/ate_pkg.sv
// shared types, codes and constants of the timestamp-to-epoch converter
package ate_pkg;

   localparam int unsigned PosWidth = 5;
   localparam int unsigned YearWidth = 14;
   localparam int unsigned FieldWidth = 7;
   localparam int unsigned EpochWidth = 38;
   localparam int unsigned MacAWidth = 22;
   localparam int unsigned MacBWidth = 17;

   localparam logic [PosWidth-1:0] TS_LEN = 5'd16;
   localparam logic [PosWidth-1:0] POS_SAT = 5'd17;
   localparam logic [PosWidth-1:0] POS_SEP_T = 5'd8;
   localparam logic [PosWidth-1:0] POS_SEP_Z = 5'd15;
   localparam logic [PosWidth-1:0] POS_MONTH = 5'd4;
   localparam logic [PosWidth-1:0] POS_DAY = 5'd6;
   localparam logic [PosWidth-1:0] POS_MINUTE = 5'd11;
   localparam logic [PosWidth-1:0] POS_SECOND = 5'd13;

   localparam logic [7:0] CHAR_T = 8'h54;
   localparam logic [7:0] CHAR_Z = 8'h5a;
   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_9 = 8'h39;

   localparam logic [YearWidth-1:0] EPOCH_YEAR = 14'd1970;
   localparam logic [11:0] LEAPS_BEFORE_EPOCH = 12'd477;

   localparam logic [MacBWidth-1:0] RECIP_100 = 17'd5243;
   localparam int unsigned RecipShift = 19;
   localparam logic [MacBWidth-1:0] DAYS_PER_YEAR = 17'd365;
   localparam logic [MacBWidth-1:0] SECS_PER_DAY = 17'd86400;
   localparam logic [MacBWidth-1:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [MacBWidth-1:0] SECS_PER_MIN = 17'd60;
   localparam logic [MacBWidth-1:0] MAC_ONE = 17'd1;

   // sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_CENT = 4'd2;
   localparam logic [3:0] ST_DAYS = 4'd3;
   localparam logic [3:0] ST_MUL_DAY = 4'd4;
   localparam logic [3:0] ST_ADD_HOUR = 4'd5;
   localparam logic [3:0] ST_ADD_MIN = 4'd6;
   localparam logic [3:0] ST_ADD_SEC = 4'd7;
   localparam logic [3:0] ST_DONE = 4'd8;

   typedef logic [FieldWidth-1:0] field_type;

   // days in a common year before the first of each month
   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] days;
      unique case (month)
         4'd1: days = 9'd0;
         4'd2: days = 9'd31;
         4'd3: days = 9'd59;
         4'd4: days = 9'd90;
         4'd5: days = 9'd120;
         4'd6: days = 9'd151;
         4'd7: days = 9'd181;
         4'd8: days = 9'd212;
         4'd9: days = 9'd243;
         4'd10: days = 9'd273;
         4'd11: days = 9'd304;
         4'd12: days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

FILE: design/ate_mac.sv
// shared multiply-add unit: res = a * b + c, truncated to the epoch width
module ate_mac (
   input  logic [ate_pkg::MacAWidth-1:0]  a,
   input  logic [ate_pkg::MacBWidth-1:0]  b,
   input  logic [ate_pkg::EpochWidth-1:0] c,
   output logic [ate_pkg::EpochWidth-1:0] res
);

   logic [ate_pkg::MacAWidth+ate_pkg::MacBWidth-1:0] product;

   assign product = a * b;
   assign res = product[ate_pkg::EpochWidth-1:0] + c;

endmodule

FILE: design/amz_timestamp_to_epoch_core.sv
// timestamp text stream to unix epoch seconds converter, top level
//
//  channel   dir  payload                              handshake
//  req_      in   tdata[7:0] ch, tlast last            tvalid / tready
//  rsp_      out  tdata[0] ok, tdata[38:1] seconds     tvalid / tready
//
// one character is taken per cycle while the block is in its idle state.
// after the last character the shared multiply-add unit runs a sequence of
// seven steps (century quotients, day count, day/hour/minute/second scaling);
// a rejected string goes from the check step straight to the final step. the
// result sits in an output register, and the next string is taken while it
// waits; a stalled result holds the sequencer in its final step. reset is
// synchronous and returns all fields to zero.
module amz_timestamp_to_epoch_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [0] ok, [38:1] epoch_seconds, [39] zero
);

   logic [3:0] state_ff, state_in;
   logic [ate_pkg::PosWidth-1:0] pos_ff, pos_in;
   logic malformed_ff, malformed_in;
   logic [ate_pkg::YearWidth-1:0] year_ff, year_in;
   ate_pkg::field_type month_ff, month_in;
   ate_pkg::field_type day_ff, day_in;
   ate_pkg::field_type hour_ff, hour_in;
   ate_pkg::field_type minute_ff, minute_in;
   ate_pkg::field_type second_ff, second_in;
   ate_pkg::field_type cent_ff, cent_in;
   logic [11:0] pre_ff, pre_in;
   logic [ate_pkg::EpochWidth-1:0] acc_ff, acc_in;
   logic ok_ff, ok_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ok_ff, rsp_ok_in;
   logic [ate_pkg::EpochWidth-1:0] rsp_secs_ff, rsp_secs_in;

   logic req_fire;
   logic is_digit;
   logic [3:0] digit;
   logic fields_ok;
   logic [ate_pkg::YearWidth-1:0] year_m1;
   logic [ate_pkg::YearWidth-1:0] year_off;
   logic [11:0] leaps;
   logic [13:0] cent_x100;
   logic leap_year;
   logic out_free;
   logic [ate_pkg::MacAWidth-1:0] mac_a;
   logic [ate_pkg::MacBWidth-1:0] mac_b;
   logic [ate_pkg::EpochWidth-1:0] mac_c;
   logic [ate_pkg::EpochWidth-1:0] mac_res;

   ate_mac u_mac (
      .a  (mac_a),
      .b  (mac_b),
      .c  (mac_c),
      .res(mac_res)
   );

   function automatic ate_pkg::field_type add_digit7(input ate_pkg::field_type acc,
                                                     input logic [3:0] d);
      return ate_pkg::field_type'({acc[3:0], 3'b000} + {acc[5:0], 1'b0}
                                  + {3'b000, d});
   endfunction

   assign req_tready = (state_ff == ate_pkg::ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign is_digit = (req_tdata >= ate_pkg::CHAR_0) && (req_tdata <= ate_pkg::CHAR_9);
   assign digit = 4'(req_tdata - ate_pkg::CHAR_0);

   assign year_m1 = year_ff - 14'd1;
   assign year_off = year_ff - ate_pkg::EPOCH_YEAR;
   // leap days before the year: (y-1)/4 - (y-1)/100 + (y-1)/400
   assign leaps = 12'(year_m1[ate_pkg::YearWidth-1:2]) - 12'(cent_ff)
                  + 12'(cent_ff[6:2]);
   assign cent_x100 = {1'b0, cent_ff, 6'b0} + {2'b0, cent_ff, 5'b0}
                      + {5'b0, cent_ff, 2'b0};
   assign leap_year = (year_ff[1:0] == 2'b00)
                      && ((year_ff != cent_x100) || (cent_ff[1:0] == 2'b00));

   assign fields_ok = !malformed_ff && (pos_ff == ate_pkg::TS_LEN)
                      && (year_ff >= ate_pkg::EPOCH_YEAR)
                      && (month_ff >= 7'd1) && (month_ff <= 7'd12)
                      && (day_ff >= 7'd1) && (day_ff <= 7'd31)
                      && (hour_ff <= 7'd23) && (minute_ff <= 7'd59)
                      && (second_ff <= 7'd60);

   // operand selection for the shared unit
   always_comb begin
      mac_a = '0;
      mac_b = ate_pkg::MAC_ONE;
      mac_c = acc_ff;
      unique case (state_ff)
         ate_pkg::ST_CHECK: begin
            mac_a = ate_pkg::MacAWidth'(year_m1);
            mac_b = ate_pkg::RECIP_100;
            mac_c = '0;
         end
         ate_pkg::ST_CENT: begin
            mac_a = ate_pkg::MacAWidth'(year_ff);
            mac_b = ate_pkg::RECIP_100;
            mac_c = '0;
         end
         ate_pkg::ST_DAYS: begin
            mac_a = ate_pkg::MacAWidth'(year_off);
            mac_b = ate_pkg::DAYS_PER_YEAR;
            mac_c = ate_pkg::EpochWidth'(pre_ff)
                    + ate_pkg::EpochWidth'((month_ff > 7'd2) && leap_year);
         end
         ate_pkg::ST_MUL_DAY: begin
            mac_a = acc_ff[ate_pkg::MacAWidth-1:0];
            mac_b = ate_pkg::SECS_PER_DAY;
            mac_c = '0;
         end
         ate_pkg::ST_ADD_HOUR: begin
            mac_a = ate_pkg::MacAWidth'(hour_ff);
            mac_b = ate_pkg::SECS_PER_HOUR;
         end
         ate_pkg::ST_ADD_MIN: begin
            mac_a = ate_pkg::MacAWidth'(minute_ff);
            mac_b = ate_pkg::SECS_PER_MIN;
         end
         ate_pkg::ST_ADD_SEC: begin
            mac_a = ate_pkg::MacAWidth'(second_ff);
         end
         default: begin
            mac_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      malformed_in = malformed_ff;
      year_in = year_ff;
      month_in = month_ff;
      day_in = day_ff;
      hour_in = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      cent_in = cent_ff;
      pre_in = pre_ff;
      acc_in = acc_ff;
      ok_in = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in = rsp_ok_ff;
      rsp_secs_in = rsp_secs_ff;

      unique case (state_ff)
         ate_pkg::ST_IDLE: begin
            if (req_fire) begin
               priority if (pos_ff >= ate_pkg::TS_LEN) begin
                  malformed_in = 1'b1;
               end else if (pos_ff == ate_pkg::POS_SEP_T) begin
                  if (req_tdata != ate_pkg::CHAR_T) malformed_in = 1'b1;
               end else if (pos_ff == ate_pkg::POS_SEP_Z) begin
                  if (req_tdata != ate_pkg::CHAR_Z) malformed_in = 1'b1;
               end else if (!is_digit) begin
                  malformed_in = 1'b1;
               end else if (pos_ff < ate_pkg::POS_MONTH) begin
                  year_in = ate_pkg::YearWidth'({year_ff, 3'b000} + {year_ff, 1'b0}
                                                + {13'd0, digit});
               end else if (pos_ff < ate_pkg::POS_DAY) begin
                  month_in = add_digit7(month_ff, digit);
               end else if (pos_ff < ate_pkg::POS_SEP_T) begin
                  day_in = add_digit7(day_ff, digit);
               end else if (pos_ff < ate_pkg::POS_MINUTE) begin
                  hour_in = add_digit7(hour_ff, digit);
               end else if (pos_ff < ate_pkg::POS_SECOND) begin
                  minute_in = add_digit7(minute_ff, digit);
               end else begin
                  second_in = add_digit7(second_ff, digit);
               end
               if (pos_ff < ate_pkg::POS_SAT) pos_in = pos_ff + 5'd1;
               if (req_tlast) state_in = ate_pkg::ST_CHECK;
            end
         end
         ate_pkg::ST_CHECK: begin
            ok_in = fields_ok;
            cent_in = mac_res[ate_pkg::RecipShift+6:ate_pkg::RecipShift];
            acc_in = '0;
            state_in = fields_ok ? ate_pkg::ST_CENT : ate_pkg::ST_DONE;
         end
         ate_pkg::ST_CENT: begin
            // cent_ff holds (y-1)/100 here; after this step it holds y/100
            pre_in = leaps - ate_pkg::LEAPS_BEFORE_EPOCH
                     + 12'(ate_pkg::days_before_month(month_ff[3:0]))
                     + 12'(day_ff) - 12'd1;
            cent_in = mac_res[ate_pkg::RecipShift+6:ate_pkg::RecipShift];
            state_in = ate_pkg::ST_DAYS;
         end
         ate_pkg::ST_DAYS: begin
            acc_in = mac_res;
            state_in = ate_pkg::ST_MUL_DAY;
         end
         ate_pkg::ST_MUL_DAY: begin
            acc_in = mac_res;
            state_in = ate_pkg::ST_ADD_HOUR;
         end
         ate_pkg::ST_ADD_HOUR: begin
            acc_in = mac_res;
            state_in = ate_pkg::ST_ADD_MIN;
         end
         ate_pkg::ST_ADD_MIN: begin
            acc_in = mac_res;
            state_in = ate_pkg::ST_ADD_SEC;
         end
         ate_pkg::ST_ADD_SEC: begin
            acc_in = mac_res;
            state_in = ate_pkg::ST_DONE;
         end
         ate_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in = ok_ff;
               rsp_secs_in = ok_ff ? acc_ff : '0;
               pos_in = '0;
               malformed_in = 1'b0;
               year_in = '0;
               month_in = '0;
               day_in = '0;
               hour_in = '0;
               minute_in = '0;
               second_in = '0;
               state_in = ate_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ate_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ate_pkg::ST_IDLE;
         pos_ff <= '0;
         malformed_ff <= 1'b0;
         year_ff <= '0;
         month_ff <= '0;
         day_ff <= '0;
         hour_ff <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         malformed_ff <= malformed_in;
         year_ff <= year_in;
         month_ff <= month_in;
         day_ff <= day_in;
         hour_ff <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cent_ff <= cent_in;
      pre_ff <= pre_in;
      acc_ff <= acc_in;
      ok_ff <= ok_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_secs_ff <= rsp_secs_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0, rsp_secs_ff, rsp_ok_ff};

endmodule

FILE: tb/sv/testbench.sv
// testbench for the timestamp-to-epoch converter: character stream in, checked epoch out
`timescale 1ns / 100ps

module testbench;

   // expected epoch results, worked out from the accepted characters
   class epoch_tracker;
      typedef struct {
         logic                           ok;
         logic [ate_pkg::EpochWidth-1:0] secs;
      } epoch_result_type;

      epoch_result_type               pending_epochs[$];
      int                             errors;
      logic [ate_pkg::PosWidth-1:0]   pos;
      logic                           bad;
      logic [ate_pkg::YearWidth-1:0]  yr;
      logic [ate_pkg::FieldWidth-1:0] mon, dy, hr, mins, secs;
      int unsigned                    cum_days[12] = '{0, 31, 59, 90, 120, 151,
                                                       181, 212, 243, 273, 304, 334};

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         pos = '0;
         bad = 1'b0;
         yr = '0;
         mon = '0;
         dy = '0;
         hr = '0;
         mins = '0;
         secs = '0;
      endfunction

      function longint unsigned leaps_prior(longint unsigned y);
         return (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
      endfunction

      function longint unsigned to_seconds();
         longint unsigned y, days;
         y = yr;
         days = 365 * (y - ate_pkg::EPOCH_YEAR) + leaps_prior(y)
                - leaps_prior(ate_pkg::EPOCH_YEAR);
         days += cum_days[mon - 1];
         if (mon > 2 && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0))
            days += 1;
         days += dy - 1;
         return days * 86400 + hr * 3600 + mins * 60 + secs;
      endfunction

      function void take_char(logic [7:0] ch, logic last);
         logic [ate_pkg::PosWidth-1:0] p;
         int unsigned                  dig;
         epoch_result_type             res;
         p = pos;
         dig = {24'd0, ch - ate_pkg::CHAR_0};
         if (p >= ate_pkg::TS_LEN)
            bad = 1'b1;
         else if (p == ate_pkg::POS_SEP_T) begin
            if (ch != ate_pkg::CHAR_T)
               bad = 1'b1;
         end else if (p == ate_pkg::POS_SEP_Z) begin
            if (ch != ate_pkg::CHAR_Z)
               bad = 1'b1;
         end else if (ch < ate_pkg::CHAR_0 || ch > ate_pkg::CHAR_9)
            bad = 1'b1;
         else if (p < ate_pkg::POS_MONTH)
            yr = ate_pkg::YearWidth'(yr * 10 + dig);
         else if (p < ate_pkg::POS_DAY)
            mon = ate_pkg::FieldWidth'(mon * 10 + dig);
         else if (p < ate_pkg::POS_SEP_T)
            dy = ate_pkg::FieldWidth'(dy * 10 + dig);
         else if (p < ate_pkg::POS_MINUTE)
            hr = ate_pkg::FieldWidth'(hr * 10 + dig);
         else if (p < ate_pkg::POS_SECOND)
            mins = ate_pkg::FieldWidth'(mins * 10 + dig);
         else
            secs = ate_pkg::FieldWidth'(secs * 10 + dig);
         if (p < ate_pkg::POS_SAT)
            pos = p + 1'b1;
         if (last) begin
            res.ok = !bad && pos == ate_pkg::TS_LEN && yr >= ate_pkg::EPOCH_YEAR &&
                     mon >= 1 && mon <= 12 && dy >= 1 && dy <= 31 &&
                     hr <= 23 && mins <= 59 && secs <= 60;
            res.secs = res.ok ? ate_pkg::EpochWidth'(to_seconds()) : '0;
            pending_epochs.push_back(res);
            clear();
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(logic [39:0] data);
         epoch_result_type want;
         if (pending_epochs.size() == 0) begin
            report_mismatch($sformatf("response %h with no request outstanding", data));
         end else begin
            want = pending_epochs.pop_front();
            if (data[0] !== want.ok)
               report_mismatch($sformatf("ok %b, expected %b", data[0], want.ok));
            if (data[38:1] !== want.secs)
               report_mismatch($sformatf("epoch %0d, expected %0d", data[38:1], want.secs));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   epoch_tracker book;
   logic [7:0]   text[$];
   int           sent = 0;
   bit           calm = 1'b0;

   amz_timestamp_to_epoch_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         book.take_char(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready)
         book.check_result(rsp_tdata);
   end

   initial begin : response_side
      bit squeezed;
      squeezed = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (!squeezed && sent >= 300) begin
            // long hold-off so the result register fills and the input backs up
            squeezed = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   task automatic push_num(int v, int n);
      int k, scale;
      scale = 1;
      for (k = 1; k < n; k++)
         scale *= 10;
      for (k = 0; k < n; k++) begin
         text.push_back(8'(ate_pkg::CHAR_0 + (v / scale) % 10));
         scale /= 10;
      end
   endtask

   task automatic compose(int y, int mo, int d, int h, int mi, int s);
      text.delete();
      push_num(y, 4);
      push_num(mo, 2);
      push_num(d, 2);
      text.push_back(ate_pkg::CHAR_T);
      push_num(h, 2);
      push_num(mi, 2);
      push_num(s, 2);
      text.push_back(ate_pkg::CHAR_Z);
   endtask

   task automatic compose_sane();
      compose($urandom_range(0, 1) ? $urandom_range(1970, 2100) : $urandom_range(1970, 9999),
              $urandom_range(1, 12), $urandom_range(1, 31), $urandom_range(0, 23),
              $urandom_range(0, 59), $urandom_range(0, 60));
   endtask

   task automatic send_text();
      int gap_odds;
      gap_odds = calm ? 0 : $urandom_range(0, 2);
      for (int i = 0; i < text.size(); i++) begin
         if (gap_odds != 0 && $urandom_range(0, 4) < gap_odds) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= text[i];
         req_tlast <= (i == text.size() - 1);
         @(posedge clock);
         while (!req_tready)
            @(posedge clock);
         sent++;
      end
   endtask

   initial begin
      int years[6] = '{1969, 1970, 1972, 2000, 2100, 9999};
      int months[6] = '{0, 1, 2, 12, 13, 99};
      int days[7] = '{0, 1, 28, 29, 31, 32, 99};
      int hours[4] = '{0, 23, 24, 99};
      int minutes[4] = '{0, 59, 60, 99};
      int seconds[5] = '{0, 59, 60, 61, 99};
      int goal, kind, n;

      book = new();
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      compose(1970, 1, 1, 0, 0, 0);
      send_text();
      compose(9999, 12, 31, 23, 59, 60);
      send_text();
      compose(2016, 12, 31, 23, 59, 60);   // leap second
      send_text();
      compose(2001, 2, 31, 12, 0, 0);      // day runs past month end
      send_text();
      compose(2000, 2, 29, 6, 30, 15);
      send_text();
      compose(2100, 3, 1, 0, 0, 1);
      send_text();
      compose(1969, 12, 31, 23, 59, 59);
      send_text();
      compose(2020, 0, 10, 0, 0, 0);
      send_text();
      compose(2020, 13, 10, 0, 0, 0);
      send_text();
      compose(2020, 5, 0, 0, 0, 0);
      send_text();
      compose(2020, 5, 32, 0, 0, 0);
      send_text();
      compose(2020, 5, 5, 24, 0, 0);
      send_text();
      compose(2020, 5, 5, 0, 60, 0);
      send_text();
      compose(2020, 5, 5, 0, 0, 61);
      send_text();
      // too short: single character, then one short of full length
      text.delete();
      text.push_back(8'(ate_pkg::CHAR_0 + 2));
      send_text();
      compose(2020, 5, 5, 1, 2, 3);
      void'(text.pop_back());
      send_text();
      // too long, past the saturation point
      compose(2020, 5, 5, 1, 2, 3);
      text.push_back(ate_pkg::CHAR_Z);
      text.push_back(ate_pkg::CHAR_0);
      send_text();
      // non-digits just outside the digit range
      compose(2020, 5, 5, 1, 2, 3);
      text[5] = ate_pkg::CHAR_0 - 1;
      send_text();
      compose(2020, 5, 5, 1, 2, 3);
      text[12] = ate_pkg::CHAR_9 + 1;
      send_text();
      compose(2020, 5, 5, 1, 2, 3);
      text[ate_pkg::POS_SEP_T] = ate_pkg::CHAR_T + 8'h20;
      send_text();
      compose(2020, 5, 5, 1, 2, 3);
      text[ate_pkg::POS_SEP_Z] = ate_pkg::CHAR_Z + 8'h20;
      send_text();
      compose(2020, 5, 5, 1, 2, 3);
      text[0] = 8'hff;
      text[1] = 8'h00;
      send_text();

      goal = 1450;
      while (sent < goal) begin
         if (sent >= goal - 150)
            calm = 1'b1;
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            compose_sane();
         end else if (kind == 6) begin
            compose($urandom_range(0, 9999), $urandom_range(0, 99), $urandom_range(0, 99),
                    $urandom_range(0, 99), $urandom_range(0, 99), $urandom_range(0, 99));
         end else if (kind == 7) begin
            compose_sane();
            case ($urandom_range(0, 2))
               0: begin
                  n = $urandom_range(1, 15);
                  while (text.size() > n)
                     void'(text.pop_back());
               end
               1: begin
                  repeat ($urandom_range(1, 4))
                     text.push_back(8'($urandom_range(0, 255)));
               end
               default: begin
                  text[$urandom_range(0, 15)] = 8'($urandom_range(0, 255));
               end
            endcase
         end else if (kind == 8) begin
            text.delete();
            repeat ($urandom_range(1, 20))
               text.push_back(8'($urandom_range(0, 255)));
         end else begin
            compose(years[$urandom_range(0, 5)], months[$urandom_range(0, 5)],
                    days[$urandom_range(0, 6)], hours[$urandom_range(0, 3)],
                    minutes[$urandom_range(0, 3)], seconds[$urandom_range(0, 4)]);
         end
         send_text();
      end
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;

      while (book.pending_epochs.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (book.errors == 0 && book.pending_epochs.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
